// ===== rtl/core/bdch_pkg.sv =====
package bdch_pkg;

  // Width of the time base; only the low TIME_W bits of the timestamp are used.
  localparam int TIME_W = 32;
  localparam int NBTN   = 3;
  localparam int DB_W   = 10;
  localparam int HOLD_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  typedef logic [TIME_W-1:0] time_t;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_POLL  = 2'd0;
  localparam logic [1:0] CMD_HELD  = 2'd1;
  localparam logic [1:0] CMD_COMBO = 2'd2;

  // Button and event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_UP     = 2'd1;
  localparam logic [1:0] EV_DOWN   = 2'd2;
  localparam logic [1:0] EV_SELECT = 2'd3;

  localparam logic [1:0] BTN_CODE [NBTN] = '{EV_UP, EV_DOWN, EV_SELECT};
  localparam int SEL_IDX = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_COMBO_FIRST  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COMBO_SECOND = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COMBO_HOLD   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_LONG_HOLD    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_COMBO_WINDOW = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SELECT_FIRE  = 3'd6;

  // Register values after reset.
  localparam logic [DB_W-1:0]   DEBOUNCE_RST     = 10'd20;
  localparam logic [HOLD_W-1:0] LONG_HOLD_RST    = 16'd500;
  localparam logic [HOLD_W-1:0] COMBO_WINDOW_RST = 16'd100;
  localparam logic [HOLD_W-1:0] SELECT_FIRE_RST  = 16'd200;

  // Stored state of one button.
  typedef struct packed {
    time_t last_edge;
    time_t press_begin;
    logic  level;
    logic  released;
    logic  held_done;
    logic  short_pend;
    logic  armed;
    logic  sel_fired;
  } btn_reg_t;

  // Status of one button handed from the per-button logic to the top level.
  typedef struct packed {
    logic  stable_now;
    logic  start;
    logic  cur_stable;
    time_t cur_press_el;
    time_t mid_press_el;
  } btn_stat_t;

endpackage

// ===== rtl/core/bdch_btn.sv =====
module bdch_btn import bdch_pkg::*; (
  input  logic             raw_i,
  input  time_t            now_i,
  input  btn_reg_t         cur_i,
  input  logic [DB_W-1:0]  debounce_i,
  input  logic             in_combo_i,
  output btn_reg_t         mid_o,
  output btn_stat_t        stat_o
);

  time_t edge_el;
  time_t press_el;
  time_t mid_edge_el;
  time_t db_ext;
  logic  chg;
  logic  stable_lvl;

  // Debounce, arming and press detection for one button within a poll.
  always_comb begin
    db_ext      = {{(TIME_W-DB_W){1'b0}}, debounce_i};
    chg         = (raw_i != cur_i.level);
    edge_el     = now_i - cur_i.last_edge;
    press_el    = now_i - cur_i.press_begin;
    mid_edge_el = chg ? '0 : edge_el;
    stable_lvl  = (mid_edge_el >= db_ext);

    mid_o = cur_i;
    if (chg) begin
      mid_o.level     = raw_i;
      mid_o.last_edge = now_i;
      mid_o.held_done = 1'b0;
    end
    if (mid_o.level && stable_lvl) begin
      mid_o.armed = 1'b1;
    end

    stat_o.stable_now = !mid_o.level && stable_lvl;
    stat_o.start      = stat_o.stable_now && cur_i.released && mid_o.armed;

    if (stat_o.start) begin
      mid_o.released    = 1'b0;
      mid_o.press_begin = now_i;
      mid_o.sel_fired   = 1'b0;
      if (in_combo_i) begin
        mid_o.short_pend = 1'b1;
      end
    end
    if (!stat_o.stable_now) begin
      mid_o.released   = 1'b1;
      mid_o.short_pend = 1'b0;
    end

    // Views on the state as it stood before this item, for the held query, and the press time after it.
    stat_o.cur_stable   = !cur_i.level && (edge_el >= db_ext);
    stat_o.cur_press_el = press_el;
    stat_o.mid_press_el = stat_o.start ? '0 : press_el;
  end

endmodule

// ===== rtl/core/button_debounce_combo_hold_core.sv =====
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | cmd, now_ms, raw_up/down/select, query_button
// result   | out       | out_valid_o / out_stall_i | event_res, flag
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per clock cycle sustained while the result side is not stalled; each item passes
// through the input register and then the result register, with the state update of all
// three buttons between the two.
// Reset clears the button and combo state and loads the register defaults.
// A stalled result holds; the input register keeps taking items until it is full.
// Configuration writes are always taken (cfg_ready_o is tied high).
module button_debounce_combo_hold_core import bdch_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [31:0]       now_ms_i,
  input  logic              raw_up_i,
  input  logic              raw_down_i,
  input  logic              raw_select_i,
  input  logic [1:0]        query_button_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_res_o,
  output logic              flag_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  logic [1:0]       cmd_q;
  time_t            now_q;
  logic [NBTN-1:0]  raw_q;
  logic [1:0]       qb_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [1:0]       ev_q, ev_d;
  logic             flag_q, flag_d;

  // Configuration registers.
  logic [1:0]        combo_first_q, combo_first_d;
  logic [1:0]        combo_second_q, combo_second_d;
  logic [HOLD_W-1:0] combo_hold_q, combo_hold_d;
  logic [DB_W-1:0]   debounce_q, debounce_d;
  logic [HOLD_W-1:0] long_hold_q, long_hold_d;
  logic [HOLD_W-1:0] combo_window_q, combo_window_d;
  logic [HOLD_W-1:0] select_fire_q, select_fire_d;

  // Button and combo state.
  btn_reg_t   btn_q [NBTN];
  btn_reg_t   btn_d [NBTN];
  btn_reg_t   btn_mid [NBTN];
  btn_stat_t  stat [NBTN];
  time_t      combo_since_q, combo_since_d;
  logic       combo_intent_q, combo_intent_d;
  logic       combo_latched_q, combo_latched_d;
  logic       combo_taken_q, combo_taken_d;

  logic            in_fire, s1_adv, cfg_fire;
  logic [NBTN-1:0] sel_a, sel_b, sel_q, in_combo, stop, en, dp, held_hit;
  logic            combo_on, combo_both;
  time_t           combo_el;

  // Handshakes: the input register advances whenever the result register is free.
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign flag_o      = flag_q;

  // Per-button decode of the combo and query selections.
  always_comb begin
    for (int i = 0; i < NBTN; i++) begin
      sel_a[i]    = (combo_first_q == BTN_CODE[i]);
      sel_b[i]    = (combo_second_q == BTN_CODE[i]);
      sel_q[i]    = (qb_q == BTN_CODE[i]);
      in_combo[i] = (combo_hold_q != '0) && (sel_a[i] || sel_b[i]);
    end
  end

  // Per-button poll logic.
  for (genvar g = 0; g < NBTN; g++) begin : g_btn
    bdch_btn u_btn (
      .raw_i      (raw_q[g]),
      .now_i      (now_q),
      .cur_i      (btn_q[g]),
      .debounce_i (debounce_q),
      .in_combo_i (in_combo[g]),
      .mid_o      (btn_mid[g]),
      .stat_o     (stat[g])
    );
  end

  // A non-combo press of up or down ends the poll there.
  always_comb begin
    for (int i = 0; i < NBTN; i++) begin
      dp[i]       = stat[i].stable_now;
      stop[i]     = stat[i].start && !in_combo[i] && (i != SEL_IDX);
      held_hit[i] = stat[i].cur_stable && !btn_q[i].held_done &&
                    (stat[i].cur_press_el >= {{(TIME_W-HOLD_W){1'b0}}, long_hold_q});
    end
    en[0] = 1'b1;
    en[1] = !stop[0];
    en[2] = !stop[0] && !stop[1];
  end

  assign combo_on   = (combo_first_q != '0) && (combo_second_q != '0) && (combo_hold_q != '0);
  assign combo_both = (|(sel_a & dp)) && (|(sel_b & dp));
  assign combo_el   = now_q - combo_since_q;

  // State update for one item, then configuration writes.
  always_comb begin
    logic found;
    found           = 1'b0;
    btn_d           = btn_q;
    combo_since_d   = combo_since_q;
    combo_intent_d  = combo_intent_q;
    combo_latched_d = combo_latched_q;
    combo_taken_d   = combo_taken_q;
    ev_d            = ev_q;
    flag_d          = flag_q;
    combo_first_d   = combo_first_q;
    combo_second_d  = combo_second_q;
    combo_hold_d    = combo_hold_q;
    debounce_d      = debounce_q;
    long_hold_d     = long_hold_q;
    combo_window_d  = combo_window_q;
    select_fire_d   = select_fire_q;

    if (s1_adv) begin
      ev_d   = EV_NONE;
      flag_d = 1'b0;
      case (cmd_q)
        CMD_POLL: begin
          for (int i = 0; i < NBTN; i++) begin
            if (en[i]) begin
              btn_d[i] = btn_mid[i];
            end
          end
          if (stop[0]) begin
            ev_d = EV_UP;
          end else if (stop[1]) begin
            ev_d = EV_DOWN;
          end else begin
            // Combo hold tracking.
            if (combo_on) begin
              if (combo_both) begin
                if (!combo_intent_q) begin
                  combo_intent_d  = 1'b1;
                  combo_since_d   = now_q;
                  combo_latched_d = 1'b0;
                  combo_taken_d   = 1'b0;
                end else if (!combo_latched_q &&
                             (combo_el >= {{(TIME_W-HOLD_W){1'b0}}, combo_hold_q})) begin
                  combo_latched_d = 1'b1;
                  combo_taken_d   = 1'b0;
                end
                for (int i = 0; i < NBTN; i++) begin
                  if (sel_a[i] || sel_b[i]) begin
                    btn_d[i].short_pend = 1'b0;
                  end
                end
              end else begin
                combo_intent_d = 1'b0;
              end
            end
            // Deferred short presses, lowest button first.
            for (int i = 0; i < NBTN; i++) begin
              if (!found && btn_d[i].short_pend &&
                  (stat[i].mid_press_el >= {{(TIME_W-HOLD_W){1'b0}}, combo_window_q})) begin
                btn_d[i].short_pend = 1'b0;
                ev_d  = BTN_CODE[i];
                found = 1'b1;
              end
            end
            // Hold-to-fire select.
            if (!found && !btn_d[SEL_IDX].released && !btn_d[SEL_IDX].sel_fired &&
                dp[SEL_IDX] &&
                (stat[SEL_IDX].mid_press_el >= {{(TIME_W-HOLD_W){1'b0}}, select_fire_q})) begin
              btn_d[SEL_IDX].sel_fired = 1'b1;
              ev_d = EV_SELECT;
            end
          end
        end
        CMD_HELD: begin
          if (|(sel_q & held_hit)) begin
            flag_d = 1'b1;
            for (int i = 0; i < NBTN; i++) begin
              if (sel_q[i]) begin
                btn_d[i].held_done = 1'b1;
              end
            end
          end
        end
        CMD_COMBO: begin
          if (combo_latched_q && !combo_taken_q) begin
            combo_taken_d = 1'b1;
            flag_d        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Writing any combo register clears the combo latch.
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_COMBO_FIRST: begin
          combo_first_d   = cfg_data_i[1:0];
          combo_intent_d  = 1'b0;
          combo_latched_d = 1'b0;
          combo_taken_d   = 1'b1;
        end
        CFG_COMBO_SECOND: begin
          combo_second_d  = cfg_data_i[1:0];
          combo_intent_d  = 1'b0;
          combo_latched_d = 1'b0;
          combo_taken_d   = 1'b1;
        end
        CFG_COMBO_HOLD: begin
          combo_hold_d    = cfg_data_i[HOLD_W-1:0];
          combo_intent_d  = 1'b0;
          combo_latched_d = 1'b0;
          combo_taken_d   = 1'b1;
        end
        CFG_DEBOUNCE:     debounce_d     = cfg_data_i[DB_W-1:0];
        CFG_LONG_HOLD:    long_hold_d    = cfg_data_i[HOLD_W-1:0];
        CFG_COMBO_WINDOW: combo_window_d = cfg_data_i[HOLD_W-1:0];
        CFG_SELECT_FIRE:  select_fire_d  = cfg_data_i[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control, configuration and button state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      combo_first_q   <= '0;
      combo_second_q  <= '0;
      combo_hold_q    <= '0;
      debounce_q      <= DEBOUNCE_RST;
      long_hold_q     <= LONG_HOLD_RST;
      combo_window_q  <= COMBO_WINDOW_RST;
      select_fire_q   <= SELECT_FIRE_RST;
      combo_since_q   <= '0;
      combo_intent_q  <= 1'b0;
      combo_latched_q <= 1'b0;
      combo_taken_q   <= 1'b1;
      for (int i = 0; i < NBTN; i++) begin
        btn_q[i].last_edge   <= '0;
        btn_q[i].press_begin <= '0;
        btn_q[i].level       <= 1'b1;
        btn_q[i].released    <= 1'b1;
        btn_q[i].held_done   <= 1'b0;
        btn_q[i].short_pend  <= 1'b0;
        btn_q[i].armed       <= (i != SEL_IDX);
        btn_q[i].sel_fired   <= 1'b0;
      end
    end else begin
      s1_valid_q      <= s1_valid_d;
      out_valid_q     <= out_valid_d;
      combo_first_q   <= combo_first_d;
      combo_second_q  <= combo_second_d;
      combo_hold_q    <= combo_hold_d;
      debounce_q      <= debounce_d;
      long_hold_q     <= long_hold_d;
      combo_window_q  <= combo_window_d;
      select_fire_q   <= select_fire_d;
      combo_since_q   <= combo_since_d;
      combo_intent_q  <= combo_intent_d;
      combo_latched_q <= combo_latched_d;
      combo_taken_q   <= combo_taken_d;
      btn_q           <= btn_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      now_q <= now_ms_i[TIME_W-1:0];
      raw_q <= {raw_select_i, raw_down_i, raw_up_i};
      qb_q  <= query_button_i;
    end
    ev_q   <= ev_d;
    flag_q <= flag_d;
  end

  // Checks on the pipeline and the combo and arming state.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i)) else $error("input stalled with room");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q) else $error("advanced item gave no result");

  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(flag_q && (ev_q != EV_NONE))) else $error("event and flag both set");

  a_combo_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && ((cfg_index_i == CFG_COMBO_FIRST) || (cfg_index_i == CFG_COMBO_SECOND) ||
                  (cfg_index_i == CFG_COMBO_HOLD)))
    |=> (!combo_latched_q && combo_taken_q)) else $error("combo write left latch set");

  a_select_arm_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    btn_q[SEL_IDX].armed |=> btn_q[SEL_IDX].armed) else $error("select lost its arming");

endmodule

// ===== dv/button_answer_checker.sv =====
module button_answer_checker import bdch_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       cmd_i,
  input  logic [31:0]      now_ms_i,
  input  logic             raw_up_i,
  input  logic             raw_down_i,
  input  logic             raw_select_i,
  input  logic [1:0]       query_button_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       event_res_i,
  input  logic             flag_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               answers_owed_o
);

  typedef struct packed {
    logic [1:0] ev;
    logic       flag;
  } answer_t;

  // Configuration as last written.
  logic [1:0]        combo_a;
  logic [1:0]        combo_b;
  logic [HOLD_W-1:0] combo_hold;
  logic [DB_W-1:0]   debounce;
  logic [HOLD_W-1:0] long_hold;
  logic [HOLD_W-1:0] combo_window;
  logic [HOLD_W-1:0] select_fire;

  // Per-button state; index 0 is up, 1 is down, 2 is select.
  time_t edge_at  [NBTN];
  time_t press_at [NBTN];
  logic  lvl_seen   [NBTN];
  logic  is_released [NBTN];
  logic  held_done  [NBTN];
  logic  short_wait [NBTN];
  logic  armed      [NBTN];
  logic  sel_fired  [NBTN];

  // Combo tracking.
  time_t combo_since;
  logic  combo_on;
  logic  combo_latch;
  logic  combo_claimed;

  answer_t owed_answers [$];
  int      mismatches;
  int      results_seen;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Elapsed time, wrapping at the width of the time base.
  function automatic time_t span(time_t now, time_t past);
    return now - past;
  endfunction

  function automatic logic held_low(int b, time_t now);
    return !lvl_seen[b] && span(now, edge_at[b]) >= time_t'(debounce);
  endfunction

  function automatic logic in_combo(logic [1:0] code);
    return combo_hold != '0 && (code == combo_a || code == combo_b);
  endfunction

  task automatic drop_combo();
    combo_on      = 1'b0;
    combo_latch   = 1'b0;
    combo_claimed = 1'b1;
  endtask

  task automatic reset_model();
    combo_a      = EV_NONE;
    combo_b      = EV_NONE;
    combo_hold   = '0;
    debounce     = DEBOUNCE_RST;
    long_hold    = LONG_HOLD_RST;
    combo_window = COMBO_WINDOW_RST;
    select_fire  = SELECT_FIRE_RST;
    for (int b = 0; b < NBTN; b++) begin
      edge_at[b]     = '0;
      press_at[b]    = '0;
      lvl_seen[b]    = 1'b1;
      is_released[b] = 1'b1;
      held_done[b]   = 1'b0;
      short_wait[b]  = 1'b0;
      armed[b]       = (BTN_CODE[b] != EV_SELECT);
      sel_fired[b]   = 1'b0;
    end
    combo_since = '0;
    drop_combo();
  endtask

  task automatic write_setting(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_COMBO_FIRST: begin
        combo_a = data[1:0];
        drop_combo();
      end
      CFG_COMBO_SECOND: begin
        combo_b = data[1:0];
        drop_combo();
      end
      CFG_COMBO_HOLD: begin
        combo_hold = data[HOLD_W-1:0];
        drop_combo();
      end
      CFG_DEBOUNCE:     debounce     = data[DB_W-1:0];
      CFG_LONG_HOLD:    long_hold    = data[HOLD_W-1:0];
      CFG_COMBO_WINDOW: combo_window = data[HOLD_W-1:0];
      CFG_SELECT_FIRE:  select_fire  = data[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // One poll: debounce each button in turn, stopping at the first event raised.
  function automatic logic [1:0] poll_buttons(time_t now, logic [2:0] raw);
    logic       dp;
    logic [1:0] code;
    int         ai;
    int         bi;
    for (int b = 0; b < NBTN; b++) begin
      code = BTN_CODE[b];
      if (raw[b] != lvl_seen[b]) begin
        lvl_seen[b]  = raw[b];
        edge_at[b]   = now;
        held_done[b] = 1'b0;
      end
      if (lvl_seen[b] && span(now, edge_at[b]) >= time_t'(debounce)) armed[b] = 1'b1;
      dp = held_low(b, now);
      if (dp && is_released[b] && armed[b]) begin
        is_released[b] = 1'b0;
        press_at[b]    = now;
        sel_fired[b]   = 1'b0;
        if (in_combo(code)) short_wait[b] = 1'b1;
        else if (code != EV_SELECT) return code;
      end
      if (!dp) begin
        is_released[b] = 1'b1;
        short_wait[b]  = 1'b0;
      end
    end

    // The combo pair held together cancels deferred shorts and may set the latch.
    if (combo_a != EV_NONE && combo_b != EV_NONE && combo_hold != '0) begin
      ai = int'(combo_a) - 1;
      bi = int'(combo_b) - 1;
      if (held_low(ai, now) && held_low(bi, now)) begin
        if (!combo_on) begin
          combo_on      = 1'b1;
          combo_since   = now;
          combo_latch   = 1'b0;
          combo_claimed = 1'b0;
        end
        short_wait[ai] = 1'b0;
        short_wait[bi] = 1'b0;
        if (!combo_latch && span(now, combo_since) >= time_t'(combo_hold)) begin
          combo_latch   = 1'b1;
          combo_claimed = 1'b0;
        end
      end else begin
        combo_on = 1'b0;
      end
    end

    // Deferred short presses whose window has run out.
    for (int b = 0; b < NBTN; b++) begin
      if (short_wait[b] && span(now, press_at[b]) >= time_t'(combo_window)) begin
        short_wait[b] = 1'b0;
        return BTN_CODE[b];
      end
    end

    // Select fires once it has been held long enough.
    if (!is_released[SEL_IDX] && !sel_fired[SEL_IDX] && held_low(SEL_IDX, now) &&
        span(now, press_at[SEL_IDX]) >= time_t'(select_fire)) begin
      sel_fired[SEL_IDX] = 1'b1;
      return EV_SELECT;
    end
    return EV_NONE;
  endfunction

  function automatic answer_t answer_item(logic [1:0] cmd, time_t now, logic [2:0] raw,
                                          logic [1:0] q);
    answer_t a;
    int      b;
    a.ev   = EV_NONE;
    a.flag = 1'b0;
    case (cmd)
      CMD_POLL: a.ev = poll_buttons(now, raw);
      CMD_HELD: begin
        if (q != EV_NONE) begin
          b = int'(q) - 1;
          if (held_low(b, now) && span(now, press_at[b]) >= time_t'(long_hold) &&
              !held_done[b]) begin
            held_done[b] = 1'b1;
            a.flag       = 1'b1;
          end
        end
      end
      CMD_COMBO: begin
        if (combo_latch && !combo_claimed) begin
          combo_claimed = 1'b1;
          a.flag        = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Watch all three channels; results are compared before the new input is predicted.
  always @(posedge clk_i) begin
    answer_t want;
    if (!rst_ni) begin
      reset_model();
      owed_answers.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_answers.size() == 0) begin
          report_mismatch("result with no answer owed", 32'(event_res_i), 32'(EV_NONE));
        end else begin
          want = owed_answers.pop_front();
          if (event_res_i !== want.ev) begin
            report_mismatch("event_res", 32'(event_res_i), 32'(want.ev));
          end
          if (flag_i !== want.flag) report_mismatch("flag", 32'(flag_i), 32'(want.flag));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) write_setting(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        owed_answers.push_back(answer_item(cmd_i, now_ms_i[TIME_W-1:0],
                                           {raw_select_i, raw_down_i, raw_up_i},
                                           query_button_i));
      end
    end
    answers_owed_o <= owed_answers.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench import bdch_pkg::*;;

  localparam logic [1:0]       CMD_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] CFG_BEYOND = 3'd7;
  localparam int               CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       cmd;
  logic [31:0]      now_ms;
  logic             raw_up;
  logic             raw_down;
  logic             raw_select;
  logic [1:0]       query_button;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       event_res;
  logic             flag;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               answers_owed;

  // Stimulus state: time base, button levels (bit 0 up, 1 down, 2 select) and settings.
  logic [31:0] cur_now;
  logic [2:0]  levels;
  int          items_sent;
  logic        calm;
  logic        hold_req;
  int          hold_left;
  int          cycle_count;
  logic [1:0]  set_fa;
  logic [1:0]  set_fb;
  int          set_chold;
  int          set_db;
  int          set_lhold;
  int          set_win;
  int          set_sfire;

  button_debounce_combo_hold_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .now_ms_i       (now_ms),
    .raw_up_i       (raw_up),
    .raw_down_i     (raw_down),
    .raw_select_i   (raw_select),
    .query_button_i (query_button),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_res_o    (event_res),
    .flag_o         (flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  button_answer_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .now_ms_i       (now_ms),
    .raw_up_i       (raw_up),
    .raw_down_i     (raw_down),
    .raw_select_i   (raw_select),
    .query_button_i (query_button),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .event_res_i    (event_res),
    .flag_i         (flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .answers_owed_o (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never drains ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall, a quiet stretch, and one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  // Offer one item, perhaps after a one-cycle gap, and hold it until the transfer.
  task automatic offer(input logic [1:0] c, input logic [31:0] t, input logic [2:0] lv,
                       input logic [1:0] q);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    now_ms       <= t;
    raw_up       <= lv[0];
    raw_down     <= lv[1];
    raw_select   <= lv[2];
    query_button <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic step_item(input int step, input logic [2:0] lv, input logic [1:0] c,
                           input logic [1:0] q);
    cur_now = cur_now + step;
    levels  = lv;
    offer(c, cur_now, lv, q);
  endtask

  // Stop offering and wait until every owed answer has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes follow one another without a gap.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused high bits of the narrow registers carry random junk.
  task automatic change_setting(input logic [1:0] fa, input logic [1:0] fb, input int ch,
                                input int db, input int lh, input int cw, input int sf);
    settle();
    write_reg(CFG_COMBO_FIRST, {14'($urandom), fa});
    write_reg(CFG_COMBO_SECOND, {14'($urandom), fb});
    write_reg(CFG_COMBO_HOLD, 16'(ch));
    write_reg(CFG_DEBOUNCE, {6'($urandom), 10'(db)});
    write_reg(CFG_LONG_HOLD, 16'(lh));
    write_reg(CFG_COMBO_WINDOW, 16'(cw));
    write_reg(CFG_SELECT_FIRE, 16'(sf));
    write_reg(CFG_BEYOND, 16'($urandom));
    cfg_valid <= 1'b0;
    set_fa    = fa;
    set_fb    = fb;
    set_chold = ch;
    set_db    = db;
    set_lhold = lh;
    set_win   = cw;
    set_sfire = sf;
  endtask

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 65) return CMD_POLL;
    if (r < 80) return CMD_HELD;
    if (r < 94) return CMD_COMBO;
    return CMD_UNUSED;
  endfunction

  // A clean press: bounce, hold with mixed commands, bounce on release, then rest.
  task automatic press_gesture();
    logic [2:0] press_mask;
    logic [2:0] pair_mask;
    int         thr;
    int         hold_max;
    int         hold_ms;
    int         step_max;
    int         bounce_max;
    int         spent;
    int         step;
    int         n;
    pair_mask = 3'b000;
    if (set_fa != EV_NONE && set_fb != EV_NONE) begin
      pair_mask = (3'b001 << (set_fa - 1)) | (3'b001 << (set_fb - 1));
    end
    if (pair_mask != 0 && $urandom_range(99) < 35) press_mask = pair_mask;
    else press_mask = 3'($urandom_range(1, 7));
    thr = set_lhold;
    if (set_win > thr) thr = set_win;
    if (set_sfire > thr) thr = set_sfire;
    if (set_chold > thr) thr = set_chold;
    hold_max   = 2 * thr + set_db + 50;
    step_max   = hold_max / 12 + 1;
    bounce_max = set_db / 2;

    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      step_item($urandom_range(0, bounce_max), levels ^ (press_mask & 3'($urandom_range(0, 7))),
                CMD_POLL, EV_NONE);
    end
    hold_ms = $urandom_range(0, hold_max);
    spent   = 0;
    do begin
      step  = $urandom_range(1, step_max);
      spent = spent + step;
      step_item(step, ~press_mask, pick_cmd(), 2'($urandom_range(0, 3)));
    end while (spent < hold_ms);

    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      step_item($urandom_range(0, bounce_max), levels ^ (press_mask & 3'($urandom_range(0, 7))),
                CMD_POLL, EV_NONE);
    end
    hold_ms = set_db + $urandom_range(1, set_db + 20);
    spent   = 0;
    do begin
      step  = $urandom_range(1, hold_ms / 3 + 1);
      spent = spent + step;
      step_item(step, 3'b111, pick_cmd(), 2'($urandom_range(0, 3)));
    end while (spent < hold_ms);
  endtask

  // Random levels and commands, with the odd jump anywhere in the time base.
  task automatic noise_burst();
    int n;
    n = $urandom_range(3, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) cur_now = $urandom();
      step_item($urandom_range(0, 60), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)));
    end
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(99) < 15) noise_burst();
      else press_gesture();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = CMD_POLL;
    now_ms       = '0;
    raw_up       = 1'b1;
    raw_down     = 1'b1;
    raw_select   = 1'b1;
    query_button = EV_NONE;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_COMBO_FIRST;
    cfg_data     = '0;
    cur_now      = '0;
    levels       = 3'b111;
    items_sent   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    set_fa       = EV_NONE;
    set_fb       = EV_NONE;
    set_chold    = 0;
    set_db       = int'(DEBOUNCE_RST);
    set_lhold    = int'(LONG_HOLD_RST);
    set_win      = int'(COMBO_WINDOW_RST);
    set_sfire    = int'(SELECT_FIRE_RST);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed presses at the reset settings: up short press and long hold, one-shot
    // held flag, held query for no button, unused command, down press, select
    // hold-to-fire, and a time base that wraps.
    step_item(0, 3'b111, CMD_POLL, EV_NONE);
    step_item(25, 3'b111, CMD_POLL, EV_NONE);
    step_item(5, 3'b110, CMD_POLL, EV_NONE);
    step_item(25, 3'b110, CMD_POLL, EV_NONE);
    step_item(245, 3'b110, CMD_HELD, EV_UP);
    step_item(260, 3'b110, CMD_HELD, EV_UP);
    step_item(10, 3'b110, CMD_HELD, EV_UP);
    step_item(0, 3'b110, CMD_HELD, EV_NONE);
    step_item(5, 3'b000, CMD_UNUSED, EV_SELECT);
    step_item(5, 3'b110, CMD_COMBO, EV_NONE);
    step_item(20, 3'b111, CMD_POLL, EV_NONE);
    step_item(30, 3'b101, CMD_POLL, EV_NONE);
    step_item(21, 3'b101, CMD_POLL, EV_NONE);
    step_item(9, 3'b011, CMD_POLL, EV_NONE);
    step_item(25, 3'b011, CMD_POLL, EV_NONE);
    step_item(205, 3'b011, CMD_POLL, EV_NONE);
    step_item(10, 3'b011, CMD_HELD, EV_SELECT);
    step_item(50, 3'b111, CMD_POLL, EV_NONE);
    cur_now = 32'hFFFF_FFF0;
    step_item(0, 3'b111, CMD_POLL, EV_NONE);
    step_item(21, 3'b110, CMD_POLL, EV_NONE);
    step_item(27, 3'b110, CMD_POLL, EV_NONE);
    step_item(20, 3'b111, CMD_POLL, EV_NONE);
    run_phase(110);

    // Up and down as the combo pair: hold both past the combo time, then read
    // the latch twice.
    change_setting(EV_UP, EV_DOWN, 300, 20, 500, 100, 200);
    step_item(100, 3'b111, CMD_POLL, EV_NONE);
    step_item(1, 3'b100, CMD_POLL, EV_NONE);
    step_item(25, 3'b100, CMD_POLL, EV_NONE);
    step_item(400, 3'b100, CMD_POLL, EV_NONE);
    step_item(1, 3'b100, CMD_COMBO, EV_NONE);
    step_item(1, 3'b100, CMD_COMBO, EV_NONE);
    step_item(10, 3'b111, CMD_POLL, EV_NONE);
    run_phase(140);

    // Lowest times, select alone as both combo buttons, time base about to wrap,
    // and a long hold-off on the result side so that the input backs up.
    change_setting(EV_SELECT, EV_SELECT, 1, 0, 0, 0, 0);
    cur_now  = 32'hFFFF_F000;
    hold_req = 1'b1;
    run_phase(120);

    // Highest times, with no idling on either side.
    change_setting(EV_DOWN, EV_SELECT, 65535, 1023, 65535, 65535, 65535);
    calm = 1'b1;
    run_phase(120);
    calm = 1'b0;

    // Random settings.
    for (int p = 0; p < 3; p++) begin
      change_setting(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     ($urandom_range(99) < 25) ? 0 : $urandom_range(1, 2000),
                     $urandom_range(0, 100), $urandom_range(1, 1500),
                     $urandom_range(0, 400), $urandom_range(0, 600));
      run_phase(100);
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && answers_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
